@@ sv/lcps_pkg.sv @@
// ----------------------------------------------------------------------------
// lcps_pkg
// shared constants, types and helpers of the led cube pwm scan generator
// ----------------------------------------------------------------------------
package lcps_pkg;

  // cube geometry
  localparam int NUM_LAYERS     = 8;
  localparam int LEDS_PER_LAYER = 16;
  localparam int NUM_BANKS      = 3;

  localparam int PIXELS      = NUM_LAYERS * LEDS_PER_LAYER;
  localparam int PIX_AW      = $clog2(PIXELS);
  localparam int PIX_W       = 12;
  localparam int DATA_TICKS  = 2 * LEDS_PER_LAYER;
  localparam int BRIGHT_STEPS = 16;
  localparam int LAYER_SHIFT = $clog2(BRIGHT_STEPS);
  localparam int STROBES     = NUM_LAYERS * BRIGHT_STEPS;
  localparam int STROBE_W    = $clog2(STROBES);

  localparam int REMAP_DEPTH = 128;
  localparam int REMAP_AW    = $clog2(REMAP_DEPTH);

  // command queue and result fifo
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCNT_W = QAW + 1;
  localparam int ODEPTH = 4;
  localparam int OAW    = $clog2(ODEPTH);
  localparam int OCNT_W = OAW + 1;

  // item modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_MAP   = 2'd2;

  // channel commands
  localparam logic [4:0] CMD_PLUS  = 5'd16;
  localparam logic [4:0] CMD_MINUS = 5'd17;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] pos;
    logic [1:0] bank;
    logic [4:0] red_cmd;
    logic [4:0] green_cmd;
    logic [4:0] blue_cmd;
    logic [6:0] target;
  } op_t;

  typedef struct packed {
    logic       shift_clock;
    logic       red_on;
    logic       green_on;
    logic       blue_on;
    logic       latch;
    logic [7:0] layer_select;
  } res_t;

  // set, saturating step or keep of one 4-bit channel
  function automatic logic [3:0] apply_cmd(input logic [4:0] cmd, input logic [3:0] old);
    logic [3:0] res;
    res = old;
    if (cmd < 5'd16) begin
      res = cmd[3:0];
    end else if (cmd == CMD_PLUS) begin
      res = (old == 4'hf) ? old : old + 4'd1;
    end else if (cmd == CMD_MINUS) begin
      res = (old == 4'h0) ? old : old - 4'd1;
    end
    return res;
  endfunction

endpackage

@@ sv/lcps_in_if.sv @@
// ----------------------------------------------------------------------------
// lcps_in_if
// input item channel: valid/ready handshake with the item fields
// ----------------------------------------------------------------------------
interface lcps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] layer;
  logic [1:0] column;
  logic [1:0] row;
  logic [1:0] bank;
  logic [4:0] red_cmd;
  logic [4:0] green_cmd;
  logic [4:0] blue_cmd;
  logic [6:0] map_target;

  modport source (
    output valid, mode, layer, column, row, bank, red_cmd, green_cmd, blue_cmd, map_target,
    input  ready
  );
  modport sink (
    input  valid, mode, layer, column, row, bank, red_cmd, green_cmd, blue_cmd, map_target,
    output ready
  );
endinterface

@@ sv/lcps_out_if.sv @@
// ----------------------------------------------------------------------------
// lcps_out_if
// result channel: valid/ready handshake with one output word
// ----------------------------------------------------------------------------
interface lcps_out_if;
  logic       valid;
  logic       ready;
  logic       shift_clock;
  logic       red_on;
  logic       green_on;
  logic       blue_on;
  logic       latch;
  logic [7:0] layer_select;

  modport source (
    output valid, shift_clock, red_on, green_on, blue_on, latch, layer_select,
    input  ready
  );
  modport sink (
    input  valid, shift_clock, red_on, green_on, blue_on, latch, layer_select,
    output ready
  );
endinterface

@@ sv/lcps_ram.sv @@
// ----------------------------------------------------------------------------
// lcps_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lcps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lcps_front.sv @@
// ----------------------------------------------------------------------------
// lcps_front
// accepts items, drops the ignored ones and queues the rest as operations
// ----------------------------------------------------------------------------
module lcps_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             hold,
  lcps_in_if.sink          in_ch,
  output logic             q_valid,
  output lcps_pkg::op_t    q_op,
  input  logic             q_pop
);

  lcps_pkg::op_t              q_mem [lcps_pkg::QDEPTH];
  logic [lcps_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [lcps_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [lcps_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       accept;
  logic                       keep;
  logic                       layer_ok;
  logic                       push;
  lcps_pkg::op_t              op_in;

  assign in_ch.ready = !hold && (cnt_r != lcps_pkg::QCNT_W'(lcps_pkg::QDEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  // classify
  always_comb begin
    layer_ok = int'(in_ch.layer) < lcps_pkg::NUM_LAYERS;
    unique case (in_ch.mode)
      lcps_pkg::MODE_TICK:  keep = 1'b1;
      lcps_pkg::MODE_PIXEL: keep = layer_ok && (int'(in_ch.bank) < lcps_pkg::NUM_BANKS);
      lcps_pkg::MODE_MAP:   keep = layer_ok;
      default:              keep = 1'b0;
    endcase
    op_in.kind      = in_ch.mode;
    op_in.pos       = {in_ch.layer, in_ch.column, in_ch.row};
    op_in.bank      = in_ch.bank;
    op_in.red_cmd   = in_ch.red_cmd;
    op_in.green_cmd = in_ch.green_cmd;
    op_in.blue_cmd  = in_ch.blue_cmd;
    op_in.target    = in_ch.map_target;
  end

  assign push = accept && keep;

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= op_in;
    end
  end

  assign q_valid = cnt_r != '0;
  assign q_op    = q_mem[rd_ptr_r];

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lcps_pkg::QCNT_W'(lcps_pkg::QDEPTH))
    else $error("queue count above depth");

endmodule

@@ sv/lcps_scan.sv @@
// ----------------------------------------------------------------------------
// lcps_scan
// back end: pixel and remap stores, pixel update, scan counters and the
// remap/pixel read pipeline that forms the output words
// ----------------------------------------------------------------------------
module lcps_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   display_bank,
  input  logic                         q_valid,
  input  lcps_pkg::op_t                q_op,
  output logic                         q_pop,
  input  logic [lcps_pkg::OCNT_W-1:0]  out_cnt,
  output logic                         res_push,
  output lcps_pkg::res_t               res_data,
  output logic                         clearing
);

  localparam int AW = lcps_pkg::PIX_AW;

  // clearing sweep
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // scan state
  logic [lcps_pkg::STROBE_W-1:0] strobe_r, strobe_nxt;
  logic [5:0]                    tick_r, tick_nxt;
  logic                          phase_r, phase_nxt;
  logic [7:0]                    scan_idx_r, scan_idx_nxt;
  logic [3:0]                    bright_r, bright_nxt;
  logic [7:0]                    drive_r, drive_nxt;
  logic [3:0]                    prev_r, prev_nxt;
  logic [2:0]                    lay;

  logic                          credit_ok;
  logic [lcps_pkg::OCNT_W:0]     used;
  logic                          pop_tick, pop_pix, pop_map;
  logic [1:0]                    bk;
  logic                          s0_data;
  lcps_pkg::res_t                s0_res;

  // pipeline stages
  logic           p1_vld_r, p1_data_r;
  lcps_pkg::res_t p1_res_r;
  logic [3:0]     p1_bright_r;
  logic [1:0]     p1_bk_r;
  logic           p2_vld_r, p2_data_r, p2_ok_r;
  lcps_pkg::res_t p2_res_r;
  logic [3:0]     p2_bright_r;
  logic [1:0]     p2_bk_r;

  logic [6:0]            remap_q;
  lcps_pkg::pixel_t      bank_q [lcps_pkg::NUM_BANKS];
  lcps_pkg::pixel_t      px;
  logic                  tgt_ok;

  // pixel update
  logic                  w1_vld_r;
  logic [6:0]            w1_pos_r;
  logic [1:0]            w1_bank_r;
  logic [4:0]            w1_red_r, w1_green_r, w1_blue_r;
  lcps_pkg::pixel_t      shadow_q;
  lcps_pkg::pixel_t      old_px, new_px;
  logic                  fwd_hit_r;
  lcps_pkg::pixel_t      fwd_data_r;
  logic                  wr_en0;
  logic [AW-1:0]         wr_addr;
  lcps_pkg::pixel_t      wr_data;

  // admission: a tick only enters when its word has a slot in the fifo
  always_comb begin
    used = (lcps_pkg::OCNT_W+1)'(out_cnt) + (lcps_pkg::OCNT_W+1)'(p1_vld_r)
         + (lcps_pkg::OCNT_W+1)'(p2_vld_r);
    credit_ok = used < (lcps_pkg::OCNT_W+1)'(lcps_pkg::ODEPTH);
  end

  assign q_pop    = q_valid && !clearing_r && ((q_op.kind != lcps_pkg::MODE_TICK) || credit_ok);
  assign pop_tick = q_pop && (q_op.kind == lcps_pkg::MODE_TICK);
  assign pop_pix  = q_pop && (q_op.kind == lcps_pkg::MODE_PIXEL);
  assign pop_map  = q_pop && (q_op.kind == lcps_pkg::MODE_MAP);
  assign clearing = clearing_r;

  assign bk = (int'(display_bank) >= lcps_pkg::NUM_BANKS) ? 2'(lcps_pkg::NUM_BANKS - 1)
                                                         : display_bank;

  // scan counters
  always_comb begin
    strobe_nxt   = strobe_r;
    tick_nxt     = tick_r;
    phase_nxt    = phase_r;
    scan_idx_nxt = scan_idx_r;
    bright_nxt   = bright_r;
    drive_nxt    = drive_r;
    prev_nxt     = prev_r;
    lay          = '0;
    s0_data      = 1'b0;
    s0_res       = '0;
    if (pop_tick) begin
      if (int'(tick_r) < lcps_pkg::DATA_TICKS) begin
        s0_data                = 1'b1;
        s0_res.shift_clock     = phase_r;
        s0_res.layer_select    = drive_r;
        phase_nxt              = !phase_r;
        tick_nxt               = tick_r + 6'd1;
        if (phase_r) begin
          scan_idx_nxt = scan_idx_r + 8'd1;
        end
      end else begin
        strobe_nxt   = (strobe_r == lcps_pkg::STROBE_W'(lcps_pkg::STROBES - 1)) ? '0
                                                                                 : strobe_r + 1'b1;
        lay          = 3'(strobe_nxt >> lcps_pkg::LAYER_SHIFT);
        scan_idx_nxt = {1'b0, lay, 4'b0000};
        drive_nxt    = 8'd1 << lay;
        tick_nxt     = '0;
        phase_nxt    = 1'b0;
        s0_res.latch = 1'b1;
        if (prev_r != {1'b0, lay}) begin
          // new layer: blank and restart brightness
          prev_nxt   = {1'b0, lay};
          bright_nxt = '0;
        end else begin
          bright_nxt          = bright_r + 4'd1;
          s0_res.layer_select = drive_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      strobe_r   <= '0;
      tick_r     <= '0;
      phase_r    <= 1'b0;
      scan_idx_r <= '0;
      bright_r   <= '0;
      drive_r    <= '0;
      prev_r     <= 4'(lcps_pkg::NUM_LAYERS);
      p1_vld_r   <= 1'b0;
      p2_vld_r   <= 1'b0;
      w1_vld_r   <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(lcps_pkg::PIXELS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      strobe_r   <= strobe_nxt;
      tick_r     <= tick_nxt;
      phase_r    <= phase_nxt;
      scan_idx_r <= scan_idx_nxt;
      bright_r   <= bright_nxt;
      drive_r    <= drive_nxt;
      prev_r     <= prev_nxt;
      p1_vld_r   <= pop_tick;
      p2_vld_r   <= p1_vld_r;
      w1_vld_r   <= pop_pix;
      fwd_hit_r  <= w1_vld_r && (w1_bank_r == 2'd0) && pop_pix && (q_op.pos == w1_pos_r);
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    p1_data_r   <= s0_data;
    p1_res_r    <= s0_res;
    p1_bright_r <= bright_r;
    p1_bk_r     <= bk;
    p2_data_r   <= p1_data_r;
    p2_res_r    <= p1_res_r;
    p2_bright_r <= p1_bright_r;
    p2_bk_r     <= p1_bk_r;
    p2_ok_r     <= tgt_ok;
    w1_pos_r    <= q_op.pos;
    w1_bank_r   <= q_op.bank;
    w1_red_r    <= q_op.red_cmd;
    w1_green_r  <= q_op.green_cmd;
    w1_blue_r   <= q_op.blue_cmd;
    fwd_data_r  <= new_px;
  end

  // remap table
  lcps_ram #(
    .WIDTH (7),
    .DEPTH (lcps_pkg::REMAP_DEPTH)
  ) u_remap (
    .clk   (clk),
    .we    (pop_map),
    .waddr (q_op.pos[lcps_pkg::REMAP_AW-1:0]),
    .wdata (q_op.target),
    .raddr (scan_idx_r[lcps_pkg::REMAP_AW-1:0]),
    .rdata (remap_q)
  );

  assign tgt_ok = {1'b0, remap_q} < 8'(lcps_pkg::PIXELS);

  // pixel update: old value always from bank 0
  always_comb begin
    old_px = fwd_hit_r ? fwd_data_r : shadow_q;
    new_px = {lcps_pkg::apply_cmd(w1_blue_r,  old_px[11:8]),
              lcps_pkg::apply_cmd(w1_green_r, old_px[7:4]),
              lcps_pkg::apply_cmd(w1_red_r,   old_px[3:0])};
    wr_addr = clearing_r ? clr_addr_r : w1_pos_r[AW-1:0];
    wr_data = clearing_r ? '0 : new_px;
    wr_en0  = clearing_r || (w1_vld_r && (w1_bank_r == 2'd0));
  end

  // copy of bank 0 read by the pixel update
  lcps_ram #(
    .WIDTH (lcps_pkg::PIX_W),
    .DEPTH (lcps_pkg::PIXELS)
  ) u_shadow0 (
    .clk   (clk),
    .we    (wr_en0),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (q_op.pos[AW-1:0]),
    .rdata (shadow_q)
  );

  for (genvar b = 0; b < lcps_pkg::NUM_BANKS; b++) begin : g_bank
    logic we_b;
    assign we_b = clearing_r || (w1_vld_r && (w1_bank_r == 2'(b)));
    lcps_ram #(
      .WIDTH (lcps_pkg::PIX_W),
      .DEPTH (lcps_pkg::PIXELS)
    ) u_bank (
      .clk   (clk),
      .we    (we_b),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (remap_q[AW-1:0]),
      .rdata (bank_q[b])
    );
  end

  // output word
  always_comb begin
    px = '0;
    for (int b = 0; b < lcps_pkg::NUM_BANKS; b++) begin
      if (p2_bk_r == 2'(b)) begin
        px = bank_q[b];
      end
    end
    if (!p2_ok_r) begin
      px = '0;
    end
    res_data = p2_res_r;
    if (p2_data_r) begin
      res_data.red_on   = p2_bright_r < px[3:0];
      res_data.green_on = p2_bright_r < px[7:4];
      res_data.blue_on  = p2_bright_r < px[11:8];
    end
  end

  assign res_push = p2_vld_r;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !q_pop)
    else $error("operation taken during clearing sweep");

  a_fwd_with_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> w1_vld_r)
    else $error("bypass hit without pending update");

  a_latch_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_data.latch) |-> !(res_data.shift_clock || res_data.red_on ||
                                       res_data.green_on || res_data.blue_on))
    else $error("latch word carries data bits");

endmodule

@@ sv/lcps_out_fifo.sv @@
// ----------------------------------------------------------------------------
// lcps_out_fifo
// small result fifo that parts the scan pipeline from the output handshake
// ----------------------------------------------------------------------------
module lcps_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  lcps_pkg::res_t              push_data,
  output logic [lcps_pkg::OCNT_W-1:0] cnt,
  lcps_out_if.source                  out_ch
);

  lcps_pkg::res_t               mem [lcps_pkg::ODEPTH];
  logic [lcps_pkg::OAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [lcps_pkg::OCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         pop;
  lcps_pkg::res_t               head;

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign head                = mem[rd_ptr_r];
  assign cnt                 = cnt_r;
  assign out_ch.valid        = cnt_r != '0;
  assign out_ch.shift_clock  = head.shift_clock;
  assign out_ch.red_on       = head.red_on;
  assign out_ch.green_on     = head.green_on;
  assign out_ch.blue_on      = head.blue_on;
  assign out_ch.latch        = head.latch;
  assign out_ch.layer_select = head.layer_select;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != lcps_pkg::OCNT_W'(lcps_pkg::ODEPTH)))
    else $error("result fifo overflow");

endmodule

@@ sv/led_cube_pwm_scan.sv @@
// ----------------------------------------------------------------------------
// led_cube_pwm_scan
// multiplexed pwm scan generator for an 8-layer rgb led cube
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake      | payload
// ---------+-----------+----------------+-------------------------------------
// in_ch    | in        | valid / ready  | mode layer column row bank cmds target
// out_ch   | out       | valid / ready  | shift_clock rgb_on latch layer_select
// cfg      | in        | cfg_we         | cfg_wdata = display_bank
//
// one item per cycle sustained while neither side stalls; a tick word passes
//   the queue slot, remap ram read, pixel ram read and result fifo in turn
// after reset the pixel banks are cleared in a sweep over all 128 entries (one
//   entry per cycle, all banks at once); in_ch.ready stays low meanwhile
// the front queue (4 transactions) and the result fifo (4 words) let each side
//   stall on its own; ticks enter the back end only with a free fifo slot
// ----------------------------------------------------------------------------
module led_cube_pwm_scan (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  lcps_in_if.sink     in_ch,
  lcps_out_if.source  out_ch
);

  // display bank register
  logic [1:0] display_bank_r;

  // front to back queue
  logic          q_valid;
  logic          q_pop;
  lcps_pkg::op_t q_op;

  // back to result fifo
  logic                        res_push;
  lcps_pkg::res_t              res_data;
  logic [lcps_pkg::OCNT_W-1:0] out_cnt;
  logic                        clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_bank_r <= '0;
    end else if (cfg_we) begin
      display_bank_r <= cfg_wdata;
    end
  end

  // front: accepts, drops ignored transactions, queues operations
  lcps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .hold    (clearing),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  // back: stores, pixel update and scan pipeline
  lcps_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .display_bank (display_bank_r),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_pop        (q_pop),
    .out_cnt      (out_cnt),
    .res_push     (res_push),
    .res_data     (res_data),
    .clearing     (clearing)
  );

  // result buffering toward the pin bus
  lcps_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .cnt       (out_cnt),
    .out_ch    (out_ch)
  );

endmodule
